FILE: hdl/fsp_pkg.sv
// Shared types and constants for the Fibonacci sphere point generator.
// No dependencies; used by every module under hdl/.
`timescale 1ns / 1ps
package fsp_pkg;

  localparam int OUT_FRAC_BITS = 15;
  localparam int CNT_W         = 17;
  localparam int IDX_W         = 16;
  localparam int COORD_W       = 16;
  localparam int Q_BITS        = OUT_FRAC_BITS + 1;   // bits of rounded |z| and of sqrt result
  localparam logic [CNT_W-1:0] COUNT_RESET = 17'd256;
  // golden angle in turns, 32-bit phase, rounded
  localparam logic [31:0] GOLDEN_STEP = 32'h61C88647;
  // CORDIC gain 0.607252935 in Q0.32
  localparam logic [31:0] CORDIC_GAIN = 32'd2608131496;
  localparam logic [31:0] ONE_SQ      = 32'(64'd1 << (2 * OUT_FRAC_BITS));

  typedef struct packed {
    logic              oor;
    logic              neg;
    logic [CNT_W-1:0]  mag;
    logic [31:0]       phase;
  } item_t;

  // atan(2^-k) in 2^32 units per turn
  function automatic logic [31:0] atan_turn(input int k);
    logic [31:0] a;
    case (k)
      0: a = 32'h20000000;  1: a = 32'h12E4051E;  2: a = 32'h09FB385B;  3: a = 32'h051111D4;
      4: a = 32'h028B0D43;  5: a = 32'h0145D7E1;  6: a = 32'h00A2F61E;  7: a = 32'h00517C55;
      8: a = 32'h0028BE53;  9: a = 32'h00145F2F; 10: a = 32'h000A2F98; 11: a = 32'h000517CC;
      12: a = 32'h00028BE6; 13: a = 32'h000145F3; 14: a = 32'h0000A2F9; 15: a = 32'h0000517C;
      16: a = 32'h000028BE; 17: a = 32'h0000145F; 18: a = 32'h00000A2F; 19: a = 32'h00000517;
      20: a = 32'h0000028B; 21: a = 32'h00000145; 22: a = 32'h000000A2; 23: a = 32'h00000051;
      24: a = 32'h00000028; 25: a = 32'h00000014; 26: a = 32'h0000000A; 27: a = 32'h00000005;
      28: a = 32'h00000002; 29: a = 32'h00000001;
      default: a = 32'h00000000;
    endcase
    return a;
  endfunction

endpackage

FILE: hdl/fibonacci_sphere_point_gen_top.sv
// Fibonacci sphere point generator, top level.
// Depends on fsp_pkg, fsp_front, fsp_queue, fsp_back.
`timescale 1ns / 1ps
// Accepts one point index per clock and returns one point per clock, in order, unless
// out_ready holds a waiting result back. 16 divider stages for z, 16 square-root stages
// for the radius and CORDIC_STEPS rotation stages set the depth.
// A full output register stalls the whole back pipeline; a two-entry queue lets the front
// keep taking indices meanwhile. point_count is written over cfg_* and must only change while
// nothing is in flight. Indices at or above point_count return zeros with the flag set.
module fibonacci_sphere_point_gen_top #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [16:0]               cfg_point_count,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [15:0]               in_point_index,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [15:0]        out_coord_x,
  output logic signed [15:0]        out_coord_y,
  output logic signed [15:0]        out_coord_z,
  output logic                      out_index_out_of_range
);

  logic [fsp_pkg::CNT_W-1:0] count_r;
  logic                      fq_valid, fq_ready, qb_valid, qb_ready;
  fsp_pkg::item_t            fq_item, qb_item;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= fsp_pkg::COUNT_RESET;
    end else if (cfg_valid) begin
      count_r <= cfg_point_count;
    end
  end

  fsp_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_point_index (in_point_index),
    .point_count    (count_r),
    .item_valid     (fq_valid),
    .item_ready     (fq_ready),
    .item           (fq_item)
  );

  fsp_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (fq_valid),
    .push_ready (fq_ready),
    .push_item  (fq_item),
    .pop_valid  (qb_valid),
    .pop_ready  (qb_ready),
    .pop_item   (qb_item)
  );

  fsp_back #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_back (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .in_valid               (qb_valid),
    .in_ready               (qb_ready),
    .in_item                (qb_item),
    .point_count            (count_r),
    .out_valid              (out_valid),
    .out_ready              (out_ready),
    .out_coord_x            (out_coord_x),
    .out_coord_y            (out_coord_y),
    .out_coord_z            (out_coord_z),
    .out_index_out_of_range (out_index_out_of_range)
  );

  a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_index_out_of_range |->
      out_coord_x == 16'sd0 && out_coord_y == 16'sd0 && out_coord_z == 16'sd0)
    else $error("out-of-range beat carries nonzero coordinates");

  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("result beat right after reset");

  a_front_hold: assert property (@(posedge clk) disable iff (!rst_n)
    fq_valid && !fq_ready |-> !in_ready)
    else $error("front took a new index while its beat was blocked");

endmodule

FILE: hdl/fsp_front.sv
// Front stage: takes an index, flags out-of-range, forms |n-1-2i| and the azimuth phase.
// Depends on fsp_pkg.
`timescale 1ns / 1ps
module fsp_front (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [fsp_pkg::IDX_W-1:0] in_point_index,
  input  logic [fsp_pkg::CNT_W-1:0] point_count,
  output logic                      item_valid,
  input  logic                      item_ready,
  output fsp_pkg::item_t            item
);

  logic           v_r;
  fsp_pkg::item_t item_r, item_nxt;
  logic [18:0]    d;
  logic [18:0]    dabs;

  assign in_ready   = !v_r || item_ready;
  assign item_valid = v_r;
  assign item       = item_r;

  always_comb begin
    d    = 19'(point_count) - 19'd1 - {2'b00, in_point_index, 1'b0};
    dabs = d[18] ? (19'd0 - d) : d;
    item_nxt.oor   = {1'b0, in_point_index} >= point_count;
    item_nxt.neg   = d[18];
    item_nxt.mag   = dabs[fsp_pkg::CNT_W-1:0];
    item_nxt.phase = 32'(in_point_index * fsp_pkg::GOLDEN_STEP);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_ready) begin
      v_r <= in_valid;
    end
    if (in_ready && in_valid) begin
      item_r <= item_nxt;
    end
  end

endmodule

FILE: hdl/fsp_queue.sv
// Two-entry queue between front and back so each side stalls on its own.
// Depends on fsp_pkg.
`timescale 1ns / 1ps
module fsp_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_valid,
  output logic           push_ready,
  input  fsp_pkg::item_t push_item,
  output logic           pop_valid,
  input  logic           pop_ready,
  output fsp_pkg::item_t pop_item
);

  fsp_pkg::item_t mem_r [0:1];
  logic           wr_ptr_r, rd_ptr_r;
  logic [1:0]     cnt_r;
  logic           push, pop;

  assign push_ready = cnt_r != 2'd2;
  assign pop_valid  = cnt_r != 2'd0;
  assign pop_item   = mem_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (pop)  rd_ptr_r <= !rd_ptr_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

FILE: hdl/fsp_back.sv
// Back pipeline: z divider, radius square root, gain multiply, CORDIC, output register.
// Depends on fsp_pkg. One global advance enable, held while the output beat waits.
`timescale 1ns / 1ps
module fsp_back #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  fsp_pkg::item_t              in_item,
  input  logic [fsp_pkg::CNT_W-1:0]   point_count,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [15:0]          out_coord_x,
  output logic signed [15:0]          out_coord_y,
  output logic signed [15:0]          out_coord_z,
  output logic                        out_index_out_of_range
);

  localparam int QN = fsp_pkg::Q_BITS;
  localparam int NS = CORDIC_STEPS;

  logic ce;

  // divider: zm = (mag*2^16 + n) / 2n
  logic [QN:0]   a_v_r;
  logic          a_oor_r [0:QN];
  logic          a_neg_r [0:QN];
  logic [31:0]   a_ph_r  [0:QN];
  logic [18:0]   a_rem_r [0:QN];
  logic [15:0]   a_low_r [0:QN];
  logic [QN-1:0] a_q_r   [0:QN];
  logic [18:0]   a_rem_nxt [1:QN];
  logic [18:0]   dv;

  // square
  logic          m_v_r, m_oor_r, m_neg_r;
  logic [31:0]   m_ph_r, m_zz_r;
  logic [QN-1:0] m_zm_r;

  // square root
  logic [QN:0]   b_v_r;
  logic          b_oor_r [0:QN];
  logic          b_neg_r [0:QN];
  logic [31:0]   b_ph_r  [0:QN];
  logic [QN-1:0] b_zm_r  [0:QN];
  logic [31:0]   b_val_r [0:QN];
  logic [17:0]   b_rem_r [0:QN];
  logic [QN-1:0] b_res_r [0:QN];
  logic [17:0]   b_rem_nxt [1:QN];
  logic          b_ge [1:QN];

  // rounding, fold, z
  logic                c_v_r, c_oor_r, c_flip_r;
  logic [QN-1:0]       c_rq_r;
  logic signed [33:0]  c_ang_r;
  logic signed [15:0]  c_z_r;
  logic signed [33:0]  ang0, ang_nxt;
  logic                flip_nxt;
  logic [15:0]         z_nxt;
  logic [47:0]         prod;

  // CORDIC
  logic [NS:0]         d_v_r;
  logic                d_oor_r  [0:NS];
  logic                d_flip_r [0:NS];
  logic signed [15:0]  d_z_r    [0:NS];
  logic signed [33:0]  d_x_r    [0:NS];
  logic signed [33:0]  d_y_r    [0:NS];
  logic signed [33:0]  d_a_r    [0:NS];
  logic signed [33:0]  d_x_nxt  [1:NS];
  logic signed [33:0]  d_y_nxt  [1:NS];
  logic signed [33:0]  d_a_nxt  [1:NS];

  logic                out_valid_r, out_oor_r;
  logic signed [15:0]  out_x_r, out_y_r, out_z_r;

  function automatic logic signed [15:0] round_out(input logic signed [33:0] v,
                                                   input logic flip);
    logic [33:0] mag;
    logic [33:0] q;
    logic        s;
    mag = v[33] ? (34'd0 - v) : v;
    q   = (mag + 34'd32768) >> 16;
    s   = v[33] ^ flip;
    if (s) begin
      round_out = (q >= 34'd32768) ? 16'sh8000 : 16'(34'd0 - q);
    end else begin
      round_out = (q >= 34'd32767) ? 16'sh7FFF : 16'(q);
    end
  endfunction

  assign ce       = !out_valid_r || out_ready;
  assign in_ready = ce;
  assign dv       = {1'b0, point_count, 1'b0};

  always_comb begin
    for (int k = 0; k < QN; k++) begin
      logic [18:0] sh;
      sh = {a_rem_r[k][17:0], a_low_r[k][15]};
      a_rem_nxt[k+1] = (sh >= dv) ? (sh - dv) : sh;
    end
    for (int k = 0; k < QN; k++) begin
      logic [19:0] sh2, trial;
      sh2   = {b_rem_r[k], b_val_r[k][31:30]};
      trial = {2'b00, b_res_r[k], 2'b01};
      b_ge[k+1]      = sh2 >= trial;
      b_rem_nxt[k+1] = b_ge[k+1] ? 18'(sh2 - trial) : 18'(sh2);
    end
  end

  // angle fold to +-1/4 turn, and saturated z
  always_comb begin
    ang0     = $signed({{2{b_ph_r[QN][31]}}, b_ph_r[QN]});
    ang_nxt  = ang0;
    flip_nxt = 1'b0;
    if (ang0 > 34'sd1073741824) begin
      ang_nxt  = ang0 - 34'sd2147483648;
      flip_nxt = 1'b1;
    end else if (ang0 < -34'sd1073741824) begin
      ang_nxt  = ang0 + 34'sd2147483648;
      flip_nxt = 1'b1;
    end
    if (b_neg_r[QN]) begin
      z_nxt = 16'(17'd0 - {1'b0, b_zm_r[QN]});
    end else begin
      z_nxt = b_zm_r[QN][15] ? 16'h7FFF : b_zm_r[QN];
    end
    prod = (48'(c_rq_r) * 48'(fsp_pkg::CORDIC_GAIN)) + 48'd32768;
  end

  always_comb begin
    for (int k = 0; k < NS; k++) begin
      logic signed [33:0] xs, ys, at;
      xs = d_x_r[k] >>> k;
      ys = d_y_r[k] >>> k;
      at = $signed({2'b00, fsp_pkg::atan_turn(k)});
      if (d_a_r[k] >= 0) begin
        d_x_nxt[k+1] = d_x_r[k] - ys;
        d_y_nxt[k+1] = d_y_r[k] + xs;
        d_a_nxt[k+1] = d_a_r[k] - at;
      end else begin
        d_x_nxt[k+1] = d_x_r[k] + ys;
        d_y_nxt[k+1] = d_y_r[k] - xs;
        d_a_nxt[k+1] = d_a_r[k] + at;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r       <= '0;
      m_v_r       <= 1'b0;
      b_v_r       <= '0;
      c_v_r       <= 1'b0;
      d_v_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (ce) begin
      a_v_r       <= {a_v_r[QN-1:0], in_valid};
      m_v_r       <= a_v_r[QN];
      b_v_r       <= {b_v_r[QN-1:0], m_v_r};
      c_v_r       <= b_v_r[QN];
      d_v_r       <= {d_v_r[NS-1:0], c_v_r};
      out_valid_r <= d_v_r[NS];
    end
    if (ce) begin
      a_oor_r[0] <= in_item.oor;
      a_neg_r[0] <= in_item.neg;
      a_ph_r[0]  <= in_item.phase;
      a_rem_r[0] <= 19'(in_item.mag) + 19'(point_count[16]);
      a_low_r[0] <= point_count[15:0];
      a_q_r[0]   <= '0;
      for (int k = 0; k < QN; k++) begin
        a_oor_r[k+1] <= a_oor_r[k];
        a_neg_r[k+1] <= a_neg_r[k];
        a_ph_r[k+1]  <= a_ph_r[k];
        a_rem_r[k+1] <= a_rem_nxt[k+1];
        a_low_r[k+1] <= {a_low_r[k][14:0], 1'b0};
        a_q_r[k+1]   <= {a_q_r[k][QN-2:0], ({a_rem_r[k][17:0], a_low_r[k][15]} >= dv)};
      end

      m_oor_r <= a_oor_r[QN];
      m_neg_r <= a_neg_r[QN];
      m_ph_r  <= a_ph_r[QN];
      m_zm_r  <= a_q_r[QN];
      m_zz_r  <= 32'(a_q_r[QN]) * 32'(a_q_r[QN]);

      b_oor_r[0] <= m_oor_r;
      b_neg_r[0] <= m_neg_r;
      b_ph_r[0]  <= m_ph_r;
      b_zm_r[0]  <= m_zm_r;
      b_val_r[0] <= (m_zz_r >= fsp_pkg::ONE_SQ) ? 32'd0 : (fsp_pkg::ONE_SQ - m_zz_r);
      b_rem_r[0] <= '0;
      b_res_r[0] <= '0;
      for (int k = 0; k < QN; k++) begin
        b_oor_r[k+1] <= b_oor_r[k];
        b_neg_r[k+1] <= b_neg_r[k];
        b_ph_r[k+1]  <= b_ph_r[k];
        b_zm_r[k+1]  <= b_zm_r[k];
        b_val_r[k+1] <= {b_val_r[k][29:0], 2'b00};
        b_rem_r[k+1] <= b_rem_nxt[k+1];
        b_res_r[k+1] <= {b_res_r[k][QN-2:0], b_ge[k+1]};
      end

      // round to nearest: remainder v - res^2 above res
      c_oor_r  <= b_oor_r[QN];
      c_rq_r   <= b_res_r[QN] + QN'(b_rem_r[QN] > {2'b00, b_res_r[QN]});
      c_ang_r  <= ang_nxt;
      c_flip_r <= flip_nxt;
      c_z_r    <= $signed(z_nxt);

      d_oor_r[0]  <= c_oor_r;
      d_flip_r[0] <= c_flip_r;
      d_z_r[0]    <= c_z_r;
      d_x_r[0]    <= $signed({2'b00, prod[47:16]});
      d_y_r[0]    <= '0;
      d_a_r[0]    <= c_ang_r;
      for (int k = 0; k < NS; k++) begin
        d_oor_r[k+1]  <= d_oor_r[k];
        d_flip_r[k+1] <= d_flip_r[k];
        d_z_r[k+1]    <= d_z_r[k];
        d_x_r[k+1]    <= d_x_nxt[k+1];
        d_y_r[k+1]    <= d_y_nxt[k+1];
        d_a_r[k+1]    <= d_a_nxt[k+1];
      end

      out_oor_r <= d_oor_r[NS];
      out_x_r   <= d_oor_r[NS] ? 16'sd0 : round_out(d_x_r[NS], d_flip_r[NS]);
      out_y_r   <= d_oor_r[NS] ? 16'sd0 : round_out(d_y_r[NS], d_flip_r[NS]);
      out_z_r   <= d_oor_r[NS] ? 16'sd0 : d_z_r[NS];
    end
  end

  assign out_valid              = out_valid_r;
  assign out_coord_x            = out_x_r;
  assign out_coord_y            = out_y_r;
  assign out_coord_z            = out_z_r;
  assign out_index_out_of_range = out_oor_r;

endmodule
